// ===== hw/rtl/sbr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and the microcode ROM for the stream byte reassembler.
// No dependencies; the unit, sequencer and datapath import this package.
package sbr_pkg;

  // Field widths of the stream channels
  localparam int BYTE_W     = 8;
  localparam int POS_W      = 64;
  localparam int CNT_OUT_W  = 7;

  // Item operation codes
  localparam logic [1:0] OP_BYTE   = 2'd0;
  localparam logic [1:0] OP_EMPTY  = 2'd1;
  localparam logic [1:0] OP_CREDIT = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  // Datapath action selected by the current control word
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_PREP,
    ACT_DECODE,
    ACT_READ,
    ACT_EMIT,
    ACT_STATUS
  } act_t;

  // Branch condition of a control word
  typedef enum logic [2:0] {
    CND_ALWAYS,
    CND_IN_BEAT,
    CND_KEEP,
    CND_RUN_OK,
    CND_LAST
  } cond_t;

  // Microprogram step addresses
  typedef enum logic [2:0] {
    ST_WAIT,
    ST_PREP,
    ST_DEC,
    ST_RUN,
    ST_EMIT,
    ST_STAT
  } step_t;

  // One control word: handshake enables, action, branch condition and targets
  typedef struct packed {
    logic  take_in;
    logic  need_out;
    act_t  act;
    cond_t cond;
    step_t jt;
    step_t jf;
  } uword_t;

  // Sequencer -> datapath
  typedef struct packed {
    logic in_ready;
    logic fire;
    act_t act;
  } sbr_ctrl_t;

  // Datapath -> sequencer
  typedef struct packed {
    logic in_beat;
    logic out_free;
    logic keep;
    logic run_ok;
    logic last;
  } sbr_flags_t;

  // Microcode ROM
  function automatic uword_t ucode_rom(input step_t s);
    uword_t w;
    w = '{take_in: 1'b0, need_out: 1'b0, act: ACT_NONE, cond: CND_ALWAYS,
          jt: ST_WAIT, jf: ST_WAIT};
    unique case (s)
      ST_WAIT: w = '{take_in: 1'b1, need_out: 1'b0, act: ACT_NONE,
                     cond: CND_IN_BEAT, jt: ST_PREP, jf: ST_WAIT};
      ST_PREP: w = '{take_in: 1'b0, need_out: 1'b0, act: ACT_PREP,
                     cond: CND_ALWAYS, jt: ST_DEC, jf: ST_DEC};
      ST_DEC:  w = '{take_in: 1'b0, need_out: 1'b0, act: ACT_DECODE,
                     cond: CND_KEEP, jt: ST_RUN, jf: ST_STAT};
      ST_RUN:  w = '{take_in: 1'b0, need_out: 1'b0, act: ACT_READ,
                     cond: CND_RUN_OK, jt: ST_EMIT, jf: ST_STAT};
      ST_EMIT: w = '{take_in: 1'b0, need_out: 1'b1, act: ACT_EMIT,
                     cond: CND_LAST, jt: ST_WAIT, jf: ST_RUN};
      ST_STAT: w = '{take_in: 1'b0, need_out: 1'b1, act: ACT_STATUS,
                     cond: CND_ALWAYS, jt: ST_WAIT, jf: ST_WAIT};
      default: w = '{take_in: 1'b0, need_out: 1'b0, act: ACT_NONE,
                     cond: CND_ALWAYS, jt: ST_WAIT, jf: ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/sbr_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the stream byte reassembler: one segment item per beat.
// No dependencies.
interface sbr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [63:0] position;
  logic [7:0] data_byte;
  logic       eof_here;
  logic [6:0] read_count;

  modport source (output valid, op, position, data_byte, eof_here, read_count,
                  input ready);
  modport sink   (input valid, op, position, data_byte, eof_here, read_count,
                  output ready);
endinterface

// ===== hw/rtl/sbr_out_if.sv =====
`timescale 1ns / 1ps
// Output channel of the stream byte reassembler: one result per beat.
// No dependencies.
interface sbr_out_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] out_byte;
  logic       stream_end;
  logic       last;
  logic [6:0] pending_count;

  modport source (output valid, has_byte, out_byte, stream_end, last, pending_count,
                  input ready);
  modport sink   (input valid, has_byte, out_byte, stream_end, last, pending_count,
                  output ready);
endinterface

// ===== hw/rtl/stream_byte_reassembler_unit.sv =====
// Stream byte reassembler. Items arrive on the segment channel: a byte tagged
// with its absolute stream position (op 0), an empty segment carrying only a
// position and possibly the end mark (op 1), or a consumer read credit (op 2).
// Bytes inside the window are held in a CAPACITY-entry store; each contiguous
// run starting at the next expected position comes out on the result channel,
// one byte per beat, with last set on the final result of the item. An item
// that releases nothing gives one status result (has_byte low).
// Timing: a microcoded sequencer runs each item. An item that stores no byte
// passes the accept, prep, decode and status steps, and its status result is
// registered in the status step. A stored byte adds a store read step: each
// released byte takes a read and an emit step, and a stored byte that releases
// nothing takes a read step and then the status step.
// Stall: while the result register is full and not taken, the emit or status
// step holds; a new item is accepted as soon as the last result of the
// previous one is registered.
// Reset (synchronous, active high) clears all stream state and every store
// valid bit; the block is ready right after it.
`timescale 1ns / 1ps
// Top level: wires the microcode sequencer to the reassembly datapath.
// Depends on sbr_pkg, sbr_in_if, sbr_out_if, sbr_sequencer, sbr_datapath.
module stream_byte_reassembler_unit #(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst,
  sbr_in_if.sink    segment,
  sbr_out_if.source result
);
  import sbr_pkg::*;

  sbr_ctrl_t  ctrl;
  sbr_flags_t flags;

  // Control sequencer
  sbr_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // Datapath and byte store
  sbr_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .flags   (flags),
    .segment (segment),
    .result  (result)
  );

endmodule

// ===== hw/rtl/sbr_sequencer.sv =====
`timescale 1ns / 1ps
// Microcode sequencer: step counter, ROM lookup and conditional branching.
// Depends on sbr_pkg.
module sbr_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  sbr_pkg::sbr_flags_t flags,
  output sbr_pkg::sbr_ctrl_t  ctrl
);
  import sbr_pkg::*;

  step_t  step;
  step_t  step_next;
  uword_t uw;
  logic   stall;
  logic   cond_hit;

  // Control word of the current step
  always_comb begin
    uw    = ucode_rom(step);
    stall = uw.need_out && !flags.out_free;
  end

  // Branch condition
  always_comb begin
    unique case (uw.cond)
      CND_ALWAYS:  cond_hit = 1'b1;
      CND_IN_BEAT: cond_hit = flags.in_beat;
      CND_KEEP:    cond_hit = flags.keep;
      CND_RUN_OK:  cond_hit = flags.run_ok;
      CND_LAST:    cond_hit = flags.last;
      default:     cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (stall) begin
      step_next = step;
    end else if (cond_hit) begin
      step_next = uw.jt;
    end else begin
      step_next = uw.jf;
    end
  end

  assign ctrl.in_ready = uw.take_in;
  assign ctrl.fire     = !stall;
  assign ctrl.act      = uw.act;

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== hw/rtl/sbr_datapath.sv =====
`timescale 1ns / 1ps
// Reassembly datapath: stream state, byte store with valid bits, output register.
// Depends on sbr_pkg, sbr_in_if and sbr_out_if.
module sbr_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  sbr_pkg::sbr_ctrl_t  ctrl,
  output sbr_pkg::sbr_flags_t flags,
  sbr_in_if.sink              segment,
  sbr_out_if.source           result
);
  import sbr_pkg::*;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam logic [SLOT_W:0]  CAP_S = (SLOT_W + 1)'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);

  // Latched item
  logic [1:0]           it_op;
  logic [POS_W-1:0]     it_pos;
  logic [BYTE_W-1:0]    it_data;
  logic                 it_eof;
  logic [CNT_OUT_W-1:0] it_rc;

  // Prep results
  logic [POS_W-1:0] diff;
  logic             pos_below;
  logic             pos_ge_end;
  logic [POS_W-1:0] end_cand;
  logic [POS_W:0]   diff_full;

  // Stream state
  logic [POS_W-1:0]  next_expected;
  logic [SLOT_W-1:0] ne_slot;
  logic [POS_W-1:0]  end_position;
  logic              end_known;
  logic              stream_closed;
  logic [CNT_W-1:0]  occupancy;
  logic [CNT_W-1:0]  pending;
  logic [CAPACITY-1:0] byte_valid;

  // Byte store
  logic [BYTE_W-1:0] byte_store [CAPACITY];
  logic [BYTE_W-1:0] rdata;

  // Output register
  logic                 o_valid;
  logic                 o_has;
  logic [BYTE_W-1:0]    o_byte;
  logic                 o_end;
  logic                 o_last;
  logic [CNT_OUT_W-1:0] o_pend;

  logic in_beat;
  logic out_free;
  logic do_prep, do_dec, do_read, do_emit, do_stat;

  // Decode terms
  logic                 is_seg;
  logic [CNT_W-1:0]     room;
  logic [CNT_W-1:0]     diff_lo;
  logic                 keep_raw;
  logic                 set_end;
  logic                 end_known_n;
  logic [POS_W-1:0]     end_pos_n;
  logic                 closed_n;
  logic                 keep;
  logic [SLOT_W:0]      slot_sum;
  logic [SLOT_W-1:0]    wr_slot;
  logic [CNT_OUT_W-1:0] occ_ext;
  logic [CNT_W-1:0]     occ_credit;

  // Release terms
  logic [POS_W-1:0]  ne_inc;
  logic [SLOT_W-1:0] slot_nx;
  logic [CNT_W-1:0]  occ_inc;
  logic              close_on_emit;
  logic              run_ok;
  logic              last_rel;

  assign in_beat  = segment.valid && ctrl.in_ready;
  assign out_free = !o_valid || result.ready;
  assign do_prep  = ctrl.fire && (ctrl.act == ACT_PREP);
  assign do_dec   = ctrl.fire && (ctrl.act == ACT_DECODE);
  assign do_read  = ctrl.fire && (ctrl.act == ACT_READ);
  assign do_emit  = ctrl.fire && (ctrl.act == ACT_EMIT);
  assign do_stat  = ctrl.fire && (ctrl.act == ACT_STATUS);

  assign segment.ready = ctrl.in_ready;

  // Position difference against next expected, with borrow
  assign diff_full = {1'b0, it_pos} - {1'b0, next_expected};

  // Decode: window, end mark and close check
  always_comb begin
    is_seg   = ((it_op == OP_BYTE) || (it_op == OP_EMPTY)) && !stream_closed
               && !pos_below;
    room     = CAP_C - occupancy;
    diff_lo  = CNT_W'(diff[SLOT_W-1:0]);
    keep_raw = (it_op == OP_BYTE) && (diff[POS_W-1:SLOT_W] == '0) && (diff_lo < room)
               && !(end_known && pos_ge_end);
    set_end     = is_seg && !end_known && it_eof;
    end_known_n = end_known || set_end;
    end_pos_n   = set_end ? end_cand : end_position;
    closed_n    = stream_closed || (is_seg && end_known_n && (next_expected == end_pos_n));
    keep        = is_seg && keep_raw && !closed_n;
    slot_sum    = {1'b0, ne_slot} + {1'b0, diff[SLOT_W-1:0]};
    wr_slot     = (slot_sum >= CAP_S) ? SLOT_W'(slot_sum - CAP_S) : slot_sum[SLOT_W-1:0];
    occ_ext     = CNT_OUT_W'(occupancy);
    occ_credit  = (it_rc >= occ_ext) ? '0 : CNT_W'(occ_ext - it_rc);
  end

  // Release: effects of handing out the byte at next expected
  always_comb begin
    ne_inc        = next_expected + 64'd1;
    slot_nx       = (ne_slot == LAST_SLOT) ? '0 : ne_slot + 1'b1;
    occ_inc       = occupancy + 1'b1;
    close_on_emit = end_known && (ne_inc == end_position);
    last_rel      = close_on_emit || !byte_valid[slot_nx] || (occ_inc >= CAP_C);
    run_ok        = !stream_closed && byte_valid[ne_slot] && (occupancy < CAP_C);
  end

  assign flags.in_beat  = in_beat;
  assign flags.out_free = out_free;
  assign flags.keep     = keep;
  assign flags.run_ok   = run_ok;
  assign flags.last     = last_rel;

  // Item latch and prep registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      it_op   <= segment.op;
      it_pos  <= segment.position;
      it_data <= segment.data_byte;
      it_eof  <= segment.eof_here;
      it_rc   <= segment.read_count;
    end
    if (do_prep) begin
      diff       <= diff_full[POS_W-1:0];
      pos_below  <= diff_full[POS_W];
      pos_ge_end <= (it_pos >= end_position);
      end_cand   <= (it_op == OP_BYTE) ? it_pos + 64'd1 : it_pos;
    end
  end

  // Byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_dec && keep) begin
      byte_store[wr_slot] <= it_data;
    end
    if (do_read) begin
      rdata <= byte_store[ne_slot];
    end
  end

  // Stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      next_expected <= '0;
      ne_slot       <= '0;
      end_position  <= '0;
      end_known     <= 1'b0;
      stream_closed <= 1'b0;
      occupancy     <= '0;
      pending       <= '0;
      byte_valid    <= '0;
    end else if (do_dec) begin
      if (it_op == OP_CREDIT) begin
        occupancy <= occ_credit;
      end
      if (is_seg) begin
        end_known     <= end_known_n;
        end_position  <= end_pos_n;
        stream_closed <= closed_n;
      end
      if (keep) begin
        byte_valid[wr_slot] <= 1'b1;
        if (!byte_valid[wr_slot]) begin
          pending <= pending + 1'b1;
        end
      end
    end else if (do_emit) begin
      byte_valid[ne_slot] <= 1'b0;
      pending             <= pending - 1'b1;
      next_expected       <= ne_inc;
      ne_slot             <= slot_nx;
      occupancy           <= occ_inc;
      stream_closed       <= stream_closed || close_on_emit;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (do_emit || do_stat) begin
      o_valid <= 1'b1;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
    if (do_emit) begin
      o_has  <= 1'b1;
      o_byte <= rdata;
      o_end  <= stream_closed || close_on_emit;
      o_last <= last_rel;
      o_pend <= CNT_OUT_W'(pending - 1'b1);
    end else if (do_stat) begin
      o_has  <= 1'b0;
      o_byte <= '0;
      o_end  <= stream_closed;
      o_last <= 1'b1;
      o_pend <= CNT_OUT_W'(pending);
    end
  end

  assign result.valid         = o_valid;
  assign result.has_byte      = o_has;
  assign result.out_byte      = o_byte;
  assign result.stream_end    = o_end;
  assign result.last          = o_last;
  assign result.pending_count = o_pend;

endmodule
